@@ src/icssst_pkg.sv @@
// Package for the ICS session state tracker.
// Holds the item and result types and the state and event codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icssst_pkg;

    localparam logic [3:0] ST_INIT          = 4'd0;
    localparam logic [3:0] ST_CONNECTING    = 4'd1;
    localparam logic [3:0] ST_ESTABLISHED   = 4'd2;
    localparam logic [3:0] ST_AUTHENTICATED = 4'd3;
    localparam logic [3:0] ST_DATA_EXCHANGE = 4'd4;
    localparam logic [3:0] ST_CLOSING       = 4'd5;
    localparam logic [3:0] ST_CLOSED        = 4'd6;
    localparam logic [3:0] ST_ERROR         = 4'd7;
    localparam logic [3:0] ST_TIMEOUT       = 4'd8;

    localparam logic [3:0] EV_CONN_REQ   = 4'd0;
    localparam logic [3:0] EV_CONN_ACC   = 4'd1;
    localparam logic [3:0] EV_CONN_REJ   = 4'd2;
    localparam logic [3:0] EV_AUTH_REQ   = 4'd3;
    localparam logic [3:0] EV_AUTH_OK    = 4'd4;
    localparam logic [3:0] EV_AUTH_FAIL  = 4'd5;
    localparam logic [3:0] EV_DATA_REQ   = 4'd6;
    localparam logic [3:0] EV_DATA_RSP   = 4'd7;
    localparam logic [3:0] EV_DATA_ERR   = 4'd8;
    localparam logic [3:0] EV_KEEPALIVE  = 4'd9;
    localparam logic [3:0] EV_CLOSE_REQ  = 4'd10;
    localparam logic [3:0] EV_CLOSE_DONE = 4'd11;
    localparam logic [3:0] EV_VIOLATION  = 4'd12;
    localparam logic [3:0] EV_TIMEOUT    = 4'd13;
    localparam logic [3:0] EV_UNEXPECTED = 4'd14;

    localparam logic [2:0] MODE_DIRECT   = 3'd0;
    localparam logic [2:0] MODE_DEFAULT  = 3'd1;
    localparam logic [2:0] MODE_MODBUS   = 3'd2;
    localparam logic [2:0] MODE_S7       = 3'd3;
    localparam logic [2:0] MODE_ENIP     = 3'd4;
    localparam logic [2:0] MODE_PROFINET = 3'd5;
    localparam logic [2:0] MODE_CLEAR    = 3'd6;

    localparam logic [15:0] PROFINET_FRAME_TYPE = 16'h9288;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  flow_index;
        logic [3:0]  event_code;
        logic [63:0] head_low;
        logic [31:0] head_high;
        logic [15:0] payload_length;
        logic        payload_found;
        logic [15:0] frame_type;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] state_after;
        logic [3:0] event_seen;
        logic       state_changed;
        logic       pair_valid;
        logic       is_terminal;
        logic       is_active;
    } t_out_beat;

    typedef struct packed {
        logic       hit;
        logic [3:0] to;
    } t_arc;

endpackage

`default_nettype wire

@@ src/icssst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module icssst_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/ics_session_state_tracker.sv @@
// Top level of the ICS session state tracker.
// Depends on icssst_pkg and icssst_ram.
`timescale 1ns / 1ps
`default_nettype none

// Tracks a session state per flow, one beat per cycle while the output side
// keeps up, through a stage register and an output register. The state table
// sits in a RAM with a registered read port: the read is issued as the beat
// is accepted, the update is written back as it leaves the stage, and the
// last write is forwarded so back-to-back beats on one flow see fresh state.
// Per-entry valid bits return every flow to INIT at reset at once, with no
// clearing pass. A beat naming a flow at or beyond FLOW_COUNT gives all zeros.
module ics_session_state_tracker
    import icssst_pkg::*;
#(
    parameter int FLOW_COUNT = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out
);

    localparam int DEPTH = (FLOW_COUNT < 256) ? FLOW_COUNT : 256;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] FLOW_LIMIT = 9'(DEPTH);

    function automatic t_arc arc_lookup(input logic [3:0] st, input logic [3:0] ev);
        t_arc a;
        a.hit = 1'b1;
        a.to  = ST_ERROR;
        unique case (st)
            ST_INIT: begin
                unique case (ev)
                    EV_CONN_REQ:  a.to = ST_CONNECTING;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_CONNECTING: begin
                unique case (ev)
                    EV_CONN_ACC:  a.to = ST_ESTABLISHED;
                    EV_CONN_REJ:  a.to = ST_ERROR;
                    EV_TIMEOUT:   a.to = ST_TIMEOUT;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_ESTABLISHED: begin
                unique case (ev)
                    EV_AUTH_REQ:  a.to = ST_ESTABLISHED;
                    EV_AUTH_OK:   a.to = ST_AUTHENTICATED;
                    EV_AUTH_FAIL: a.to = ST_ERROR;
                    EV_DATA_REQ:  a.to = ST_DATA_EXCHANGE;
                    EV_DATA_RSP:  a.to = ST_DATA_EXCHANGE;
                    EV_KEEPALIVE: a.to = ST_ESTABLISHED;
                    EV_CLOSE_REQ: a.to = ST_CLOSING;
                    EV_TIMEOUT:   a.to = ST_TIMEOUT;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_AUTHENTICATED: begin
                unique case (ev)
                    EV_DATA_REQ:  a.to = ST_DATA_EXCHANGE;
                    EV_DATA_RSP:  a.to = ST_DATA_EXCHANGE;
                    EV_KEEPALIVE: a.to = ST_AUTHENTICATED;
                    EV_CLOSE_REQ: a.to = ST_CLOSING;
                    EV_TIMEOUT:   a.to = ST_TIMEOUT;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_DATA_EXCHANGE: begin
                unique case (ev)
                    EV_DATA_REQ:  a.to = ST_DATA_EXCHANGE;
                    EV_DATA_RSP:  a.to = ST_DATA_EXCHANGE;
                    EV_DATA_ERR:  a.to = ST_DATA_EXCHANGE;
                    EV_KEEPALIVE: a.to = ST_DATA_EXCHANGE;
                    EV_CLOSE_REQ: a.to = ST_CLOSING;
                    EV_TIMEOUT:   a.to = ST_TIMEOUT;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_CLOSING: begin
                unique case (ev)
                    EV_CLOSE_DONE: a.to = ST_CLOSED;
                    EV_TIMEOUT:    a.to = ST_CLOSED;
                    EV_VIOLATION:  a.to = ST_ERROR;
                    default:       a.hit = 1'b0;
                endcase
            end
            default: a.hit = 1'b0;
        endcase
        return a;
    endfunction

    function automatic logic [3:0] classify(input t_in_beat b, input logic [3:0] st);
        logic [3:0]  ev;
        logic [15:0] len;
        logic [7:0]  b5;
        logic [15:0] cmd;
        logic [31:0] handle;
        logic [31:0] status;
        logic [15:0] fid;
        logic [7:0]  svc;
        len    = b.payload_length;
        b5     = b.head_low[47:40];
        cmd    = b.head_low[15:0];
        handle = b.head_low[63:32];
        status = b.head_high;
        fid    = {b.head_low[7:0], b.head_low[15:8]};
        svc    = b.head_low[23:16];
        ev     = EV_UNEXPECTED;
        unique case (b.mode)
            MODE_MODBUS: begin
                if (len < 16'd8) begin
                    ev = EV_VIOLATION;
                end else if (b.head_low[63]) begin
                    ev = EV_DATA_ERR;
                end else if (st == ST_INIT || st == ST_CONNECTING) begin
                    ev = EV_CONN_ACC;
                end else begin
                    ev = EV_DATA_REQ;
                end
            end
            MODE_S7: begin
                if (len < 16'd10) begin
                    ev = EV_VIOLATION;
                end else if (b5 == 8'hE0) begin
                    ev = EV_CONN_REQ;
                end else if (b5 == 8'hD0) begin
                    ev = EV_CONN_ACC;
                end else if (b5 == 8'hF0) begin
                    if (len < 16'd12) begin
                        ev = EV_VIOLATION;
                    end else if (b.head_high[7:0] == 8'h01) begin
                        ev = EV_DATA_REQ;
                    end else if (b.head_high[7:0] == 8'h03) begin
                        ev = EV_DATA_RSP;
                    end else begin
                        ev = EV_UNEXPECTED;
                    end
                end else if (b5 == 8'h80) begin
                    ev = EV_CLOSE_REQ;
                end else begin
                    ev = EV_UNEXPECTED;
                end
            end
            MODE_ENIP: begin
                if (!b.payload_found || len < 16'd24) begin
                    ev = EV_VIOLATION;
                end else if (cmd == 16'h0065) begin
                    if (handle == 32'd0) begin
                        ev = EV_CONN_REQ;
                    end else begin
                        ev = (status == 32'd0) ? EV_CONN_ACC : EV_CONN_REJ;
                    end
                end else if (cmd == 16'h0066) begin
                    ev = EV_CLOSE_REQ;
                end else if (cmd == 16'h006F) begin
                    ev = (status != 32'd0) ? EV_DATA_ERR : EV_DATA_REQ;
                end else if (cmd == 16'h0004 || cmd == 16'h0063) begin
                    ev = EV_DATA_REQ;
                end else begin
                    ev = EV_UNEXPECTED;
                end
            end
            MODE_PROFINET: begin
                if (b.frame_type != PROFINET_FRAME_TYPE || len < 16'd4) begin
                    ev = EV_VIOLATION;
                end else if (fid >= 16'hFEFC && fid <= 16'hFEFF
                             && (svc == 8'h03 || svc == 8'h04 || svc == 8'h05)) begin
                    ev = EV_DATA_REQ;
                end else if (fid >= 16'hC000 && fid <= 16'hFAFF) begin
                    ev = EV_DATA_REQ;
                end else if (st == ST_INIT) begin
                    ev = EV_CONN_ACC;
                end else begin
                    ev = EV_DATA_REQ;
                end
            end
            default: begin
                if (st == ST_INIT) begin
                    ev = EV_CONN_REQ;
                end else if (st == ST_CONNECTING) begin
                    ev = EV_CONN_ACC;
                end else if (st == ST_ESTABLISHED || st == ST_AUTHENTICATED
                             || st == ST_DATA_EXCHANGE) begin
                    ev = EV_DATA_REQ;
                end else begin
                    ev = EV_UNEXPECTED;
                end
            end
        endcase
        return ev;
    endfunction

    logic             r_s1_valid;
    t_in_beat         r_s1;
    logic [DEPTH-1:0] r_vbit;
    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_idx;
    logic [3:0]       r_fwd_state;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic             in_accept;
    logic             s1_adv;
    logic [AW-1:0]    s1_addr;
    logic             s1_in_range;
    logic [3:0]       ram_rdata;
    logic [3:0]       old_state;
    logic [3:0]       n_state;
    logic [3:0]       ev;
    logic             pair_ok;
    t_arc             arc;
    logic             s1_write;
    t_out_beat        n_out;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    assign s1_addr     = r_s1.flow_index[AW-1:0];
    assign s1_in_range = {1'b0, r_s1.flow_index} < FLOW_LIMIT;

    icssst_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_write),
        .i_waddr (s1_addr),
        .i_wdata (n_state),
        .i_re    (in_accept),
        .i_raddr (i_in.flow_index[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        priority if (r_fwd_valid && r_fwd_idx == s1_addr) begin
            old_state = r_fwd_state;
        end else if (r_vbit[s1_addr]) begin
            old_state = ram_rdata;
        end else begin
            old_state = ST_INIT;
        end

        ev      = 4'd0;
        pair_ok = 1'b0;
        n_state = old_state;
        arc     = '0;
        unique case (r_s1.mode)
            MODE_DIRECT: begin
                ev      = r_s1.event_code;
                arc     = arc_lookup(old_state, ev);
                pair_ok = arc.hit;
                n_state = arc.hit ? arc.to : old_state;
            end
            MODE_DEFAULT, MODE_MODBUS, MODE_S7, MODE_ENIP, MODE_PROFINET: begin
                ev      = classify(r_s1, old_state);
                arc     = arc_lookup(old_state, ev);
                pair_ok = arc.hit;
                n_state = arc.hit ? arc.to : ST_ERROR;
            end
            MODE_CLEAR: begin
                n_state = ST_INIT;
            end
            default: begin
                n_state = old_state;
            end
        endcase

        if (s1_in_range) begin
            n_out.state_after   = n_state;
            n_out.event_seen    = ev;
            n_out.state_changed = n_state != old_state;
            n_out.pair_valid    = pair_ok;
            n_out.is_terminal   = n_state == ST_CLOSED || n_state == ST_ERROR
                                  || n_state == ST_TIMEOUT;
            n_out.is_active     = n_state == ST_DATA_EXCHANGE
                                  || n_state == ST_AUTHENTICATED;
        end else begin
            n_out = '0;
        end

        s1_write = s1_adv && s1_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_vbit      <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_write) begin
                r_vbit[s1_addr] <= 1'b1;
                r_fwd_valid     <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_s1 <= i_in;
        end
        if (s1_write) begin
            r_fwd_idx   <= s1_addr;
            r_fwd_state <= n_state;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.is_terminal && o_out.is_active))
        else $error("terminal and active flags both set");

    a_invalid_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.pair_valid && o_out.state_changed)
        |-> (o_out.state_after == ST_ERROR || o_out.state_after == ST_INIT))
        else $error("state changed without a table pair to a state other than error or init");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> o_out_valid)
        else $error("stage beat did not reach the output register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

@@ verif/icssst_tb_pkg.sv @@
// Protocol header constants shared by the session tracker checker and testbench.
// Depends on nothing; the block's own codes come from icssst_pkg.
`timescale 1ns / 1ps

package icssst_tb_pkg;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [3:0] EV_UNUSED   = 4'd15;

    localparam int MODBUS_MIN_LEN  = 8;
    localparam int S7_MIN_LEN      = 10;
    localparam int S7_DATA_MIN_LEN = 12;
    localparam int ENIP_MIN_LEN    = 24;
    localparam int PN_MIN_LEN      = 4;
    localparam int MODBUS_EXC_BIT  = 63;

    localparam logic [7:0] S7_PDU_CONN_REQ    = 8'hE0;
    localparam logic [7:0] S7_PDU_CONN_CONF   = 8'hD0;
    localparam logic [7:0] S7_PDU_DATA        = 8'hF0;
    localparam logic [7:0] S7_PDU_DISC_REQ    = 8'h80;
    localparam logic [7:0] S7_ROSCTR_JOB      = 8'h01;
    localparam logic [7:0] S7_ROSCTR_ACK_DATA = 8'h03;

    localparam logic [15:0] ENIP_REGISTER      = 16'h0065;
    localparam logic [15:0] ENIP_UNREGISTER    = 16'h0066;
    localparam logic [15:0] ENIP_SEND_RR       = 16'h006F;
    localparam logic [15:0] ENIP_LIST_SERVICES = 16'h0004;
    localparam logic [15:0] ENIP_LIST_IDENTITY = 16'h0063;

    localparam logic [15:0] PN_FID_DCP_LO = 16'hFEFC;
    localparam logic [15:0] PN_FID_DCP_HI = 16'hFEFF;
    localparam logic [15:0] PN_FID_RT_LO  = 16'hC000;
    localparam logic [15:0] PN_FID_RT_HI  = 16'hFAFF;

    localparam logic [7:0] PN_SVC_GET      = 8'h03;
    localparam logic [7:0] PN_SVC_SET      = 8'h04;
    localparam logic [7:0] PN_SVC_IDENTIFY = 8'h05;

endpackage

@@ verif/icssst_checker.sv @@
// Checker for the session tracker: predicts each result from the accepted beats
// and compares it with the output channel. Depends on icssst_pkg and icssst_tb_pkg.
`timescale 1ns / 1ps

module icssst_checker
    import icssst_pkg::*;
    import icssst_tb_pkg::*;
#(
    parameter int FLOW_COUNT = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_LIMIT = 200;

    logic [3:0] flow_state [FLOW_COUNT];
    t_out_beat  due_results[$];
    int         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_arc arc_of(logic [3:0] st, logic [3:0] ev);
        t_arc a;
        a.hit = 1'b1;
        a.to  = ST_ERROR;
        case (st)
            ST_INIT: begin
                case (ev)
                    EV_CONN_REQ:  a.to = ST_CONNECTING;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_CONNECTING: begin
                case (ev)
                    EV_CONN_ACC:               a.to = ST_ESTABLISHED;
                    EV_CONN_REJ, EV_VIOLATION: a.to = ST_ERROR;
                    EV_TIMEOUT:                a.to = ST_TIMEOUT;
                    default:                   a.hit = 1'b0;
                endcase
            end
            ST_ESTABLISHED: begin
                case (ev)
                    EV_AUTH_REQ, EV_KEEPALIVE:  a.to = ST_ESTABLISHED;
                    EV_AUTH_OK:                 a.to = ST_AUTHENTICATED;
                    EV_AUTH_FAIL, EV_VIOLATION: a.to = ST_ERROR;
                    EV_DATA_REQ, EV_DATA_RSP:   a.to = ST_DATA_EXCHANGE;
                    EV_CLOSE_REQ:               a.to = ST_CLOSING;
                    EV_TIMEOUT:                 a.to = ST_TIMEOUT;
                    default:                    a.hit = 1'b0;
                endcase
            end
            ST_AUTHENTICATED: begin
                case (ev)
                    EV_DATA_REQ, EV_DATA_RSP: a.to = ST_DATA_EXCHANGE;
                    EV_KEEPALIVE:             a.to = ST_AUTHENTICATED;
                    EV_CLOSE_REQ:             a.to = ST_CLOSING;
                    EV_TIMEOUT:               a.to = ST_TIMEOUT;
                    EV_VIOLATION:             a.to = ST_ERROR;
                    default:                  a.hit = 1'b0;
                endcase
            end
            ST_DATA_EXCHANGE: begin
                case (ev)
                    EV_DATA_REQ, EV_DATA_RSP, EV_DATA_ERR, EV_KEEPALIVE:
                                  a.to = ST_DATA_EXCHANGE;
                    EV_CLOSE_REQ: a.to = ST_CLOSING;
                    EV_TIMEOUT:   a.to = ST_TIMEOUT;
                    EV_VIOLATION: a.to = ST_ERROR;
                    default:      a.hit = 1'b0;
                endcase
            end
            ST_CLOSING: begin
                case (ev)
                    EV_CLOSE_DONE, EV_TIMEOUT: a.to = ST_CLOSED;
                    EV_VIOLATION:              a.to = ST_ERROR;
                    default:                   a.hit = 1'b0;
                endcase
            end
            default: a.hit = 1'b0;
        endcase
        return a;
    endfunction

    function automatic logic [3:0] classify_header(t_in_beat b, logic [3:0] st);
        logic [7:0]  pdu;
        logic [7:0]  rosctr;
        logic [7:0]  svc;
        logic [15:0] cmd;
        logic [15:0] fid;
        logic [31:0] handle;
        logic [31:0] status;
        logic [3:0]  ev;
        pdu    = b.head_low[47:40];
        rosctr = b.head_high[7:0];
        svc    = b.head_low[23:16];
        cmd    = b.head_low[15:0];
        fid    = {b.head_low[7:0], b.head_low[15:8]};
        handle = b.head_low[63:32];
        status = b.head_high;
        case (b.mode)
            MODE_MODBUS: begin
                if (b.payload_length < MODBUS_MIN_LEN) ev = EV_VIOLATION;
                else if (b.head_low[MODBUS_EXC_BIT]) ev = EV_DATA_ERR;
                else if (st == ST_INIT || st == ST_CONNECTING) ev = EV_CONN_ACC;
                else ev = EV_DATA_REQ;
            end
            MODE_S7: begin
                if (b.payload_length < S7_MIN_LEN) ev = EV_VIOLATION;
                else if (pdu == S7_PDU_CONN_REQ) ev = EV_CONN_REQ;
                else if (pdu == S7_PDU_CONN_CONF) ev = EV_CONN_ACC;
                else if (pdu == S7_PDU_DATA) begin
                    if (b.payload_length < S7_DATA_MIN_LEN) ev = EV_VIOLATION;
                    else if (rosctr == S7_ROSCTR_JOB) ev = EV_DATA_REQ;
                    else if (rosctr == S7_ROSCTR_ACK_DATA) ev = EV_DATA_RSP;
                    else ev = EV_UNEXPECTED;
                end
                else if (pdu == S7_PDU_DISC_REQ) ev = EV_CLOSE_REQ;
                else ev = EV_UNEXPECTED;
            end
            MODE_ENIP: begin
                if (!b.payload_found || b.payload_length < ENIP_MIN_LEN) ev = EV_VIOLATION;
                else if (cmd == ENIP_REGISTER) begin
                    if (handle == '0) ev = EV_CONN_REQ;
                    else ev = (status == '0) ? EV_CONN_ACC : EV_CONN_REJ;
                end
                else if (cmd == ENIP_UNREGISTER) ev = EV_CLOSE_REQ;
                else if (cmd == ENIP_SEND_RR) ev = (status != '0) ? EV_DATA_ERR : EV_DATA_REQ;
                else if (cmd == ENIP_LIST_SERVICES || cmd == ENIP_LIST_IDENTITY) ev = EV_DATA_REQ;
                else ev = EV_UNEXPECTED;
            end
            MODE_PROFINET: begin
                if (b.frame_type != PROFINET_FRAME_TYPE || b.payload_length < PN_MIN_LEN)
                    ev = EV_VIOLATION;
                else if (fid >= PN_FID_DCP_LO && fid <= PN_FID_DCP_HI &&
                         (svc == PN_SVC_GET || svc == PN_SVC_SET || svc == PN_SVC_IDENTIFY))
                    ev = EV_DATA_REQ;
                else if (fid >= PN_FID_RT_LO && fid <= PN_FID_RT_HI) ev = EV_DATA_REQ;
                else if (st == ST_INIT) ev = EV_CONN_ACC;
                else ev = EV_DATA_REQ;
            end
            default: begin
                if (st == ST_INIT) ev = EV_CONN_REQ;
                else if (st == ST_CONNECTING) ev = EV_CONN_ACC;
                else if (st == ST_ESTABLISHED || st == ST_AUTHENTICATED ||
                         st == ST_DATA_EXCHANGE) ev = EV_DATA_REQ;
                else ev = EV_UNEXPECTED;
            end
        endcase
        return ev;
    endfunction

    function automatic t_out_beat session_step(t_in_beat b, logic [3:0] prior);
        t_out_beat  r;
        t_arc       a;
        logic [3:0] nst;
        r   = '0;
        nst = prior;
        case (b.mode)
            MODE_DIRECT: begin
                r.event_seen = b.event_code;
                a            = arc_of(prior, r.event_seen);
                r.pair_valid = a.hit;
                if (a.hit) nst = a.to;
            end
            MODE_DEFAULT, MODE_MODBUS, MODE_S7, MODE_ENIP, MODE_PROFINET: begin
                r.event_seen = classify_header(b, prior);
                a            = arc_of(prior, r.event_seen);
                r.pair_valid = a.hit;
                nst          = a.hit ? a.to : ST_ERROR;
            end
            MODE_CLEAR: nst = ST_INIT;
            default: ;
        endcase
        r.state_after   = nst;
        r.state_changed = (nst != prior);
        r.is_terminal   = (nst == ST_CLOSED) || (nst == ST_ERROR) || (nst == ST_TIMEOUT);
        r.is_active     = (nst == ST_DATA_EXCHANGE) || (nst == ST_AUTHENTICATED);
        return r;
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            for (int f = 0; f < FLOW_COUNT; f++) flow_state[f] = ST_INIT;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (int'(i_in.flow_index) >= FLOW_COUNT) begin
                    want = '0;
                end else begin
                    want = session_step(i_in, flow_state[i_in.flow_index]);
                    flow_state[i_in.flow_index] = want.state_after;
                end
                due_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat expected none actual state %0d event %0d",
                                 $time, i_out.state_after, i_out.event_seen);
                end else begin
                    want = due_results.pop_front();
                    check_field("state_after", want.state_after, i_out.state_after);
                    check_field("event_seen", want.event_seen, i_out.event_seen);
                    check_field("state_changed", 4'(want.state_changed), 4'(i_out.state_changed));
                    check_field("pair_valid", 4'(want.pair_valid), 4'(i_out.pair_valid));
                    check_field("is_terminal", 4'(want.is_terminal), 4'(i_out.is_terminal));
                    check_field("is_active", 4'(want.is_active), 4'(i_out.is_active));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the ICS session state tracker: drives beats and output stalls,
// gives the verdict. Depends on icssst_pkg, icssst_tb_pkg and icssst_checker.
`timescale 1ns / 1ps

module tb;
    import icssst_pkg::*;
    import icssst_tb_pkg::*;

    localparam int FLOW_COUNT   = 256;
    localparam int TOTAL_BEATS  = 1675;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out;

    int fail_count;
    int pending;
    int beats_sent;
    int stall_cycles = 0;
    bit quiet;

    t_in_beat scripts[4][$];

    always #5 i_clk = ~i_clk;

    ics_session_state_tracker #(
        .FLOW_COUNT (FLOW_COUNT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    icssst_checker #(
        .FLOW_COUNT (FLOW_COUNT)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ics_session_state_tracker regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] ok_len(int min_len);
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(min_len, 65535));
        return 16'($urandom_range(min_len, min_len + 60));
    endfunction

    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b.mode          = 3'($urandom_range(0, 7));
        b.flow_index    = 8'($urandom_range(0, 255));
        b.event_code    = 4'($urandom_range(0, 15));
        b.head_low      = {$urandom, $urandom};
        b.head_high     = $urandom;
        b.payload_length = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 40));
        b.payload_found = 1'($urandom_range(0, 1));
        b.frame_type    = ($urandom_range(0, 3) == 0) ? PROFINET_FRAME_TYPE
                                                      : 16'($urandom_range(0, 65535));
        return b;
    endfunction

    function automatic t_in_beat base_beat(logic [7:0] flow, logic [2:0] mode);
        t_in_beat b;
        b            = noise_beat();
        b.flow_index = flow;
        b.mode       = mode;
        return b;
    endfunction

    function automatic t_in_beat direct_beat(logic [7:0] flow, logic [3:0] ev);
        t_in_beat b;
        b            = base_beat(flow, MODE_DIRECT);
        b.event_code = ev;
        return b;
    endfunction

    function automatic t_in_beat clear_beat(logic [7:0] flow);
        return base_beat(flow, MODE_CLEAR);
    endfunction

    function automatic t_in_beat default_beat(logic [7:0] flow);
        return base_beat(flow, MODE_DEFAULT);
    endfunction

    function automatic t_in_beat modbus_beat(logic [7:0] flow, logic exc);
        t_in_beat b;
        b                          = base_beat(flow, MODE_MODBUS);
        b.payload_length           = ok_len(MODBUS_MIN_LEN);
        b.head_low[MODBUS_EXC_BIT] = exc;
        return b;
    endfunction

    function automatic t_in_beat s7_beat(logic [7:0] flow, logic [7:0] pdu, logic [7:0] rosctr);
        t_in_beat b;
        b                 = base_beat(flow, MODE_S7);
        b.payload_length  = ok_len(S7_DATA_MIN_LEN);
        b.head_low[47:40] = pdu;
        b.head_high[7:0]  = rosctr;
        return b;
    endfunction

    function automatic t_in_beat enip_beat(logic [7:0] flow, logic [15:0] cmd,
                                           logic [31:0] handle, logic [31:0] status);
        t_in_beat b;
        b                 = base_beat(flow, MODE_ENIP);
        b.payload_found   = 1'b1;
        b.payload_length  = ok_len(ENIP_MIN_LEN);
        b.head_low[15:0]  = cmd;
        b.head_low[63:32] = handle;
        b.head_high       = status;
        return b;
    endfunction

    function automatic t_in_beat pn_beat(logic [7:0] flow, logic [15:0] fid, logic [7:0] svc);
        t_in_beat b;
        b                 = base_beat(flow, MODE_PROFINET);
        b.frame_type      = PROFINET_FRAME_TYPE;
        b.payload_length  = ok_len(PN_MIN_LEN);
        b.head_low[7:0]   = fid[15:8];
        b.head_low[15:8]  = fid[7:0];
        b.head_low[23:16] = svc;
        return b;
    endfunction

    function automatic logic [31:0] nonzero_word();
        logic [31:0] w;
        w = $urandom;
        if (w == '0) w = 32'd1;
        return w;
    endfunction

    task automatic send_beat(t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = b;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic close_session(int slot, logic [7:0] flow);
        scripts[slot].push_back(direct_beat(flow,
            ($urandom_range(0, 3) == 0) ? EV_TIMEOUT : EV_CLOSE_DONE));
        if ($urandom_range(0, 3) == 0) scripts[slot].push_back(clear_beat(flow));
    endtask

    task automatic build_script(int slot, logic [7:0] flow);
        int       n;
        int       r;
        t_in_beat b;
        logic [15:0] fid;
        logic [3:0]  ev;
        if ($urandom_range(0, 3) != 0) scripts[slot].push_back(clear_beat(flow));
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 5))
            0: begin
                scripts[slot].push_back(direct_beat(flow, EV_CONN_REQ));
                r  = $urandom_range(0, 19);
                ev = (r == 0) ? EV_CONN_REJ : (r == 1) ? EV_TIMEOUT : EV_CONN_ACC;
                scripts[slot].push_back(direct_beat(flow, ev));
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(0, 2))
                        scripts[slot].push_back(direct_beat(flow, EV_AUTH_REQ));
                    ev = ($urandom_range(0, 9) == 0) ? EV_AUTH_FAIL : EV_AUTH_OK;
                    scripts[slot].push_back(direct_beat(flow, ev));
                end
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: ev = EV_DATA_REQ;
                        1: ev = EV_DATA_RSP;
                        2: ev = EV_DATA_ERR;
                        default: ev = EV_KEEPALIVE;
                    endcase
                    scripts[slot].push_back(direct_beat(flow, ev));
                end
                scripts[slot].push_back(direct_beat(flow,
                    ($urandom_range(0, 7) == 0) ? EV_TIMEOUT : EV_CLOSE_REQ));
                close_session(slot, flow);
            end
            1: begin
                repeat (n + 1) scripts[slot].push_back(default_beat(flow));
                scripts[slot].push_back(direct_beat(flow, EV_CLOSE_REQ));
                close_session(slot, flow);
            end
            2: begin
                scripts[slot].push_back(direct_beat(flow, EV_CONN_REQ));
                scripts[slot].push_back(modbus_beat(flow, 1'b0));
                repeat (n)
                    scripts[slot].push_back(modbus_beat(flow, $urandom_range(0, 6) == 0));
                scripts[slot].push_back(direct_beat(flow, EV_CLOSE_REQ));
                close_session(slot, flow);
            end
            3: begin
                scripts[slot].push_back(s7_beat(flow, S7_PDU_CONN_REQ, 8'($urandom)));
                scripts[slot].push_back(s7_beat(flow, S7_PDU_CONN_CONF, 8'($urandom)));
                repeat (n) begin
                    r = $urandom_range(0, 9);
                    scripts[slot].push_back(s7_beat(flow, S7_PDU_DATA,
                        (r < 5) ? S7_ROSCTR_JOB : (r < 9) ? S7_ROSCTR_ACK_DATA : 8'($urandom)));
                end
                scripts[slot].push_back(s7_beat(flow, S7_PDU_DISC_REQ, 8'($urandom)));
                close_session(slot, flow);
            end
            4: begin
                scripts[slot].push_back(enip_beat(flow, ENIP_REGISTER, '0, $urandom));
                scripts[slot].push_back(enip_beat(flow, ENIP_REGISTER, nonzero_word(), '0));
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0, 1: b = enip_beat(flow, ENIP_SEND_RR, $urandom, '0);
                        2: b = enip_beat(flow, ENIP_SEND_RR, $urandom, nonzero_word());
                        3: b = enip_beat(flow, ENIP_LIST_SERVICES, $urandom, $urandom);
                        4: b = enip_beat(flow, ENIP_LIST_IDENTITY, $urandom, $urandom);
                        default: b = enip_beat(flow, 16'($urandom), $urandom, $urandom);
                    endcase
                    scripts[slot].push_back(b);
                end
                scripts[slot].push_back(enip_beat(flow, ENIP_UNREGISTER, $urandom, $urandom));
                close_session(slot, flow);
            end
            default: begin
                scripts[slot].push_back(direct_beat(flow, EV_CONN_REQ));
                scripts[slot].push_back(direct_beat(flow, EV_CONN_ACC));
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            fid = PN_FID_DCP_LO + 16'($urandom_range(0, 3));
                            b   = pn_beat(flow, fid, PN_SVC_GET + 8'($urandom_range(0, 3)));
                        end
                        1: b = pn_beat(flow, 16'($urandom_range(PN_FID_RT_LO, PN_FID_RT_HI)),
                                       8'($urandom));
                        default: b = pn_beat(flow, 16'($urandom), 8'($urandom));
                    endcase
                    scripts[slot].push_back(b);
                end
                scripts[slot].push_back(direct_beat(flow, EV_CLOSE_REQ));
                close_session(slot, flow);
            end
        endcase
        if ($urandom_range(0, 7) == 0) begin
            b            = noise_beat();
            b.flow_index = flow;
            scripts[slot].insert($urandom_range(0, scripts[slot].size()), b);
        end
    endtask

    initial begin : out_pacing
        int hold;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = pick_gap();
            if (hold != 0) begin
                i_out_ready = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_in_beat   b;
        int         lanes;
        int         k;
        logic [7:0] base;
        logic [7:0] stride;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        quiet      = 1'b0;
        beats_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        b = '0;
        send_beat(b);
        b = direct_beat(8'd0, EV_UNUSED);
        send_beat(b);
        b = base_beat(8'd0, MODE_UNUSED);
        send_beat(b);
        send_beat(default_beat(8'd0));
        b = modbus_beat(8'd0, 1'b0);
        b.payload_length = 16'(MODBUS_MIN_LEN);
        send_beat(b);
        send_beat(modbus_beat(8'd0, 1'b1));
        b = modbus_beat(8'd0, 1'b0);
        b.payload_length = 16'(MODBUS_MIN_LEN - 1);
        send_beat(b);
        b.payload_length = '0;
        send_beat(b);
        send_beat(clear_beat(8'd0));
        send_beat(clear_beat(8'd0));
        b = s7_beat(8'hFF, S7_PDU_CONN_REQ, 8'($urandom));
        b.payload_length = 16'(S7_MIN_LEN);
        send_beat(b);
        send_beat(s7_beat(8'hFF, S7_PDU_CONN_CONF, 8'($urandom)));
        b = s7_beat(8'hFF, S7_PDU_DATA, S7_ROSCTR_JOB);
        b.payload_length = 16'(S7_DATA_MIN_LEN);
        send_beat(b);
        send_beat(s7_beat(8'hFF, S7_PDU_DATA, S7_ROSCTR_ACK_DATA));
        send_beat(s7_beat(8'hFF, S7_PDU_DISC_REQ, 8'($urandom)));
        send_beat(direct_beat(8'hFF, EV_CLOSE_DONE));
        b = s7_beat(8'hFF, S7_PDU_DATA, S7_ROSCTR_JOB);
        b.payload_length = 16'(S7_DATA_MIN_LEN - 1);
        send_beat(b);
        b = enip_beat(8'd1, ENIP_REGISTER, '0, '0);
        b.payload_found = 1'b0;
        send_beat(b);
        send_beat(clear_beat(8'd1));
        b = enip_beat(8'd1, ENIP_REGISTER, '0, '0);
        b.payload_length = 16'(ENIP_MIN_LEN);
        send_beat(b);
        send_beat(enip_beat(8'd1, ENIP_REGISTER, 32'd1, 32'd5));
        b = pn_beat(8'd2, PN_FID_RT_LO, 8'($urandom));
        b.frame_type = PROFINET_FRAME_TYPE + 16'd1;
        send_beat(b);
        send_beat(clear_beat(8'd2));
        b = pn_beat(8'd2, PN_FID_DCP_HI, PN_SVC_IDENTIFY);
        b.payload_length = 16'(PN_MIN_LEN);
        send_beat(b);
        send_beat(clear_beat(8'd3));
        send_beat(pn_beat(8'd3, PN_FID_DCP_HI + 16'd1, PN_SVC_GET));
        b = default_beat(8'hFF);
        b.event_code     = '1;
        b.head_low       = '1;
        b.head_high      = '1;
        b.payload_length = '1;
        b.payload_found  = 1'b1;
        b.frame_type     = '1;
        send_beat(b);

        while (beats_sent < TOTAL_BEATS) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
                lanes  = $urandom_range(1, 4);
                base   = 8'($urandom_range(0, 255));
                stride = 8'($urandom_range(0, 127) * 2 + 1);
                for (k = 0; k < lanes; k++) build_script(k, 8'(base + stride * 8'(k)));
                // interleave the sessions beat by beat
                while (scripts[0].size() + scripts[1].size() +
                       scripts[2].size() + scripts[3].size() != 0) begin
                    k = $urandom_range(0, 3);
                    if (scripts[k].size() != 0) send_beat(scripts[k].pop_front());
                end
            end else begin
                repeat ($urandom_range(1, 8)) send_beat(noise_beat());
            end
        end
        i_in_valid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ics_session_state_tracker regression: pass");
        end else begin
            $display("ics_session_state_tracker regression: fail");
        end
        $finish;
    end

endmodule
